>>> src/sht_pkg.sv
`timescale 1ns / 1ps
package sht_pkg;

   localparam int TABLE_SIZE  = 32;   // power of two: the hash keeps the low slot bits
   localparam int LABEL_CHARS = 6;
   localparam int LABEL_W     = 48;
   localparam int ADDR_W      = 24;
   localparam int STATUS_W    = 3;
   localparam int LABEL_BYTES = LABEL_W / 8;
   localparam int SLOT_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int SUM_W       = 8 + $clog2(LABEL_BYTES + 1);
   localparam int ENTRY_W     = LABEL_W + ADDR_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FULL      = 3'd2,
      ST_DELETED   = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic {
      BK_IDLE,
      BK_SCAN
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [LABEL_W-1:0]  label;
      logic [ADDR_W-1:0]   address;
      logic [SLOT_W-1:0]   key;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [LABEL_W-1:0] label_mask();
      logic [LABEL_W-1:0] m;
      m = '0;
      for (int b = 0; b < LABEL_BYTES; b++) begin
         if (b < LABEL_CHARS) begin
            m[8*b +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

   localparam logic [LABEL_W-1:0] LABEL_MASK = label_mask();

   // sum of the label bytes, folded to a slot
   function automatic logic [SLOT_W-1:0] hash_of(input logic [LABEL_W-1:0] lab);
      logic [SUM_W-1:0] sum;
      sum = '0;
      for (int b = 0; b < LABEL_BYTES; b++) begin
         sum = sum + SUM_W'(lab[8*b +: 8]);
      end
      return sum[SLOT_W-1:0];
   endfunction

endpackage

>>> src/sht_ram.sv
`timescale 1ns / 1ps
module sht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/sht_queue.sv
`timescale 1ns / 1ps
module sht_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  sht_pkg::item_type         push_item,
   input  logic                      pop,
   output sht_pkg::item_type         head_item,
   output sht_pkg::queue_status_type q_status
);

   sht_pkg::item_type             entries_ff [sht_pkg::QUEUE_DEPTH];
   logic [sht_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [sht_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [sht_pkg::QCNT_W-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == sht_pkg::QPTR_W'(sht_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == sht_pkg::QPTR_W'(sht_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item      = entries_ff[rd_ptr_ff];
   assign q_status.full  = (count_ff == sht_pkg::QCNT_W'(sht_pkg::QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("queue push while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue pop while empty");

endmodule

>>> src/sht_front.sv
`timescale 1ns / 1ps
module sht_front (
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [sht_pkg::LABEL_W-1:0]   req_label,
   input  logic [sht_pkg::ADDR_W-1:0]    req_address,
   input  sht_pkg::queue_status_type     q_status,
   output logic                          push,
   output sht_pkg::item_type             push_item
);

   logic [sht_pkg::LABEL_W-1:0] label_clean;

   assign label_clean = req_label & sht_pkg::LABEL_MASK;

   assign busy = q_status.full;
   assign push = start && !busy;

   // classify and hash on the way in so the back starts probing at once
   assign push_item.op      = sht_pkg::op_type'(req_type);
   assign push_item.label   = label_clean;
   assign push_item.address = req_address;
   assign push_item.key     = sht_pkg::hash_of(label_clean);

endmodule

>>> src/sht_back.sv
`timescale 1ns / 1ps
module sht_back (
   input  logic                           clock,
   input  logic                           reset,
   input  sht_pkg::queue_status_type      q_status,
   input  sht_pkg::item_type              head_item,
   output logic                           pop,
   output logic                           rsp_strobe,
   output logic [sht_pkg::STATUS_W-1:0]   rsp_status,
   output logic [sht_pkg::SLOT_W-1:0]     rsp_slot
);

   sht_pkg::back_state_type         state_ff, state_in;
   sht_pkg::op_type                 op_ff, op_in;
   logic [sht_pkg::LABEL_W-1:0]     label_ff, label_in;
   logic [sht_pkg::ADDR_W-1:0]      addr_ff, addr_in;
   logic [sht_pkg::SLOT_W-1:0]      probe_ff, probe_in;
   logic [sht_pkg::CNT_W-1:0]       issued_ff, issued_in;
   logic                            cmp_vld_ff, cmp_vld_in;
   logic [sht_pkg::SLOT_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                            cmp_last_ff, cmp_last_in;
   logic                            free_found_ff, free_found_in;
   logic [sht_pkg::SLOT_W-1:0]      free_slot_ff, free_slot_in;
   logic [sht_pkg::TABLE_SIZE-1:0]  valid_ff, valid_in;
   logic                            rsp_strobe_ff, rsp_strobe_in;
   sht_pkg::status_type             rsp_status_ff, rsp_status_in;
   logic [sht_pkg::SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;

   logic                            issue;
   logic                            hit;
   logic                            cand_free;
   logic                            have_free;
   logic [sht_pkg::SLOT_W-1:0]      free_pick;
   logic                            finish;
   logic                            wr_en;
   logic [sht_pkg::ENTRY_W-1:0]     rd_data;
   logic [sht_pkg::LABEL_W-1:0]     rd_label;

   sht_ram #(
      .WIDTH (sht_pkg::ENTRY_W),
      .DEPTH (sht_pkg::TABLE_SIZE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_pick),
      .wr_data ({label_ff, addr_ff}),
      .rd_en   (issue),
      .rd_addr (probe_ff),
      .rd_data (rd_data)
   );

   assign rd_label  = rd_data[sht_pkg::ENTRY_W-1 -: sht_pkg::LABEL_W];
   assign issue     = (state_ff == sht_pkg::BK_SCAN) &&
                      (issued_ff != sht_pkg::CNT_W'(sht_pkg::TABLE_SIZE));
   assign hit       = cmp_vld_ff && valid_ff[cmp_idx_ff] && (rd_label == label_ff);
   assign cand_free = cmp_vld_ff && !valid_ff[cmp_idx_ff];
   assign have_free = free_found_ff || cand_free;
   assign free_pick = free_found_ff ? free_slot_ff : cmp_idx_ff;
   assign finish    = cmp_vld_ff && (hit || cmp_last_ff);
   assign wr_en     = finish && (op_ff == sht_pkg::OP_INSERT) && !hit && have_free;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      label_in      = label_ff;
      addr_in       = addr_ff;
      probe_in      = probe_ff;
      issued_in     = issued_ff;
      cmp_vld_in    = 1'b0;
      cmp_idx_in    = probe_ff;
      cmp_last_in   = (issued_ff == sht_pkg::CNT_W'(sht_pkg::TABLE_SIZE - 1));
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      valid_in      = valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      pop           = 1'b0;

      unique case (state_ff)
         sht_pkg::BK_IDLE: begin
            if (!q_status.empty) begin
               pop           = 1'b1;
               op_in         = head_item.op;
               label_in      = head_item.label;
               addr_in       = head_item.address;
               probe_in      = head_item.key;
               issued_in     = '0;
               free_found_in = 1'b0;
               state_in      = sht_pkg::BK_SCAN;
            end
         end
         sht_pkg::BK_SCAN: begin
            // probe from the hash slot upward; the match scan rides the same pass
            if (issue) begin
               probe_in  = probe_ff + 1'b1;
               issued_in = issued_ff + 1'b1;
            end
            cmp_vld_in = issue && !finish;
            if (cand_free && !free_found_ff) begin
               free_found_in = 1'b1;
               free_slot_in  = cmp_idx_ff;
            end
            if (finish) begin
               state_in      = sht_pkg::BK_IDLE;
               rsp_strobe_in = 1'b1;
               if (op_ff == sht_pkg::OP_INSERT) begin
                  if (hit) begin
                     rsp_status_in = sht_pkg::ST_DUPLICATE;
                     rsp_slot_in   = cmp_idx_ff;
                  end else if (have_free) begin
                     rsp_status_in       = sht_pkg::ST_INSERTED;
                     rsp_slot_in         = free_pick;
                     valid_in[free_pick] = 1'b1;
                  end else begin
                     rsp_status_in = sht_pkg::ST_FULL;
                     rsp_slot_in   = '0;
                  end
               end else begin
                  if (hit) begin
                     rsp_status_in        = sht_pkg::ST_DELETED;
                     rsp_slot_in          = cmp_idx_ff;
                     valid_in[cmp_idx_ff] = 1'b0;
                  end else begin
                     rsp_status_in = sht_pkg::ST_NOT_FOUND;
                     rsp_slot_in   = '0;
                  end
               end
            end
         end
         default: begin
            state_in = sht_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= sht_pkg::BK_IDLE;
         cmp_vld_ff    <= 1'b0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cmp_vld_ff    <= cmp_vld_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      label_ff      <= label_in;
      addr_ff       <= addr_in;
      probe_ff      <= probe_in;
      issued_ff     <= issued_in;
      cmp_idx_ff    <= cmp_idx_in;
      cmp_last_ff   <= cmp_last_in;
      free_found_ff <= free_found_in;
      free_slot_ff  <= free_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("result strobe held for more than one cycle");

   a_insert_marks: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff == sht_pkg::ST_INSERTED)) |-> valid_ff[rsp_slot_ff])
      else $error("inserted slot not marked valid");

   a_delete_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && (rsp_status_ff == sht_pkg::ST_DELETED)) |-> !valid_ff[rsp_slot_ff])
      else $error("deleted slot still marked valid");

   a_miss_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && ((rsp_status_ff == sht_pkg::ST_FULL) ||
                         (rsp_status_ff == sht_pkg::ST_NOT_FOUND))) |-> (rsp_slot_ff == '0))
      else $error("slot not zero on full or not found");

endmodule

>>> src/symbol_hash_table_top.sv
`timescale 1ns / 1ps
// Symbol table: labels and addresses in a 32-slot open-addressed hash table.
// Request channel: drive req_type (insert or delete), req_label and
// req_address with start; the beat is taken on an edge where start is high
// and busy is low. busy rises only when the two-entry request queue is full.
// Result channel: one beat per request, rsp_status and rsp_slot valid for
// the single cycle that rsp_strobe is high. The receiver cannot stall it.
// A request is hashed and queued on entry; the back end then walks all slots
// from the hash slot through one registered-read port of the entry RAM,
// checking for an exact valid match, where it stops, and noting the first free slot.
// A new label inserted, a full table or a delete that misses is answered
// only after the back end has read every slot; a duplicate insert or a
// delete that hits returns sooner, depending on where the match sits in
// the probe order.
// The back end takes one request at a time: it pops it from the queue,
// reads one slot per cycle and compares each read, and stops early once
// the match is found.
// Reset clears the valid marks, the queue and all control; no sweep of the
// entry RAM is needed and requests are taken the cycle after reset drops.
module symbol_hash_table_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_type,
   input  logic [sht_pkg::LABEL_W-1:0]   req_label,
   input  logic [sht_pkg::ADDR_W-1:0]    req_address,
   output logic                          rsp_strobe,
   output logic [sht_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sht_pkg::SLOT_W-1:0]    rsp_slot
);

   logic                       push;
   logic                       pop;
   sht_pkg::item_type          push_item;
   sht_pkg::item_type          head_item;
   sht_pkg::queue_status_type  q_status;

   sht_front u_front (
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_label   (req_label),
      .req_address (req_address),
      .q_status    (q_status),
      .push        (push),
      .push_item   (push_item)
   );

   sht_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   sht_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_slot   (rsp_slot)
   );

endmodule

>>> verif/symbol_hash_table_top_tb.sv
`timescale 1ns / 1ps
module symbol_hash_table_top_tb;

   localparam int RANDOM_BEATS = 1300;
   localparam int POOL_SIZE    = 48;

   localparam logic [sht_pkg::LABEL_W-1:0] LBL_ZERO = 48'h0;
   localparam logic [sht_pkg::LABEL_W-1:0] LBL_ONES = 48'hFFFF_FFFF_FFFF;
   localparam logic [sht_pkg::LABEL_W-1:0] LBL_ABC  = 48'h4142_4300_0000;
   localparam logic [sht_pkg::LABEL_W-1:0] LBL_AB   = 48'h4142_0000_0000;
   localparam logic [sht_pkg::LABEL_W-1:0] LBL_BA   = 48'h4241_0000_0000;
   localparam logic [sht_pkg::LABEL_W-1:0] LBL_1F   = 48'h0000_0000_001F;
   localparam logic [sht_pkg::LABEL_W-1:0] LBL_3F   = 48'h0000_0000_003F;

   class symtab_scoreboard;
      typedef struct packed {
         sht_pkg::status_type         st;
         logic [sht_pkg::SLOT_W-1:0]  slot;
      } outcome_type;

      logic [sht_pkg::LABEL_W-1:0] label_tab [sht_pkg::TABLE_SIZE];
      bit                          live      [sht_pkg::TABLE_SIZE];
      outcome_type                 pending_q [$];
      int errors, n_ins, n_dup, n_full, n_del, n_miss;

      function new();
         foreach (live[i]) live[i] = 1'b0;
         errors = 0; n_ins = 0; n_dup = 0; n_full = 0; n_del = 0; n_miss = 0;
      endfunction

      // work out the answer to an accepted request and update the table copy
      function void note_request(sht_pkg::op_type op, logic [sht_pkg::LABEL_W-1:0] raw);
         logic [sht_pkg::LABEL_W-1:0] lab;
         int unsigned                 total;
         int                          hit;
         int                          probe;
         outcome_type                 res;
         lab   = '0;
         total = 0;
         hit   = -1;
         for (int b = 0; b < sht_pkg::LABEL_CHARS; b++) begin
            lab[8*b +: 8] = raw[8*b +: 8];
            total += raw[8*b +: 8];
         end
         for (int i = 0; i < sht_pkg::TABLE_SIZE; i++)
            if (hit < 0 && live[i] && label_tab[i] == lab) hit = i;
         res.slot = '0;
         if (op == sht_pkg::OP_INSERT) begin
            if (hit >= 0) begin
               res.st = sht_pkg::ST_DUPLICATE;
               res.slot = hit[sht_pkg::SLOT_W-1:0];
               n_dup++;
            end else begin
               res.st = sht_pkg::ST_FULL;
               probe = total % sht_pkg::TABLE_SIZE;
               for (int n = 0; n < sht_pkg::TABLE_SIZE; n++) begin
                  if (res.st == sht_pkg::ST_FULL && !live[probe]) begin
                     label_tab[probe] = lab;
                     live[probe] = 1'b1;
                     res.st = sht_pkg::ST_INSERTED;
                     res.slot = probe[sht_pkg::SLOT_W-1:0];
                  end
                  probe = (probe + 1) % sht_pkg::TABLE_SIZE;
               end
               if (res.st == sht_pkg::ST_INSERTED) n_ins++;
               else n_full++;
            end
         end else begin
            if (hit >= 0) begin
               live[hit] = 1'b0;
               res.st = sht_pkg::ST_DELETED;
               res.slot = hit[sht_pkg::SLOT_W-1:0];
               n_del++;
            end else begin
               res.st = sht_pkg::ST_NOT_FOUND;
               n_miss++;
            end
         end
         pending_q.push_back(res);
      endfunction

      function void check_result(logic [sht_pkg::STATUS_W-1:0] st,
                                 logic [sht_pkg::SLOT_W-1:0] slot);
         outcome_type want;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected result beat, status %0d slot %0d", $realtime, st, slot);
         end else begin
            want = pending_q.pop_front();
            if (st !== want.st || slot !== want.slot) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: mismatch: expected status %0d slot %0d, got status %0d slot %0d",
                           $realtime, want.st, want.slot, st, slot);
            end
         end
      endfunction

      function int outstanding();
         return pending_q.size();
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_type;
   logic [sht_pkg::LABEL_W-1:0]  req_label;
   logic [sht_pkg::ADDR_W-1:0]   req_address;
   logic                         rsp_strobe;
   logic [sht_pkg::STATUS_W-1:0] rsp_status;
   logic [sht_pkg::SLOT_W-1:0]   rsp_slot;

   symtab_scoreboard             sb;
   logic [sht_pkg::LABEL_W-1:0]  label_pool [POOL_SIZE];
   int                           beats_sent;

   symbol_hash_table_top DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_type    (req_type),
      .req_label   (req_label),
      .req_address (req_address),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_slot    (rsp_slot)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe) sb.check_result(rsp_status, rsp_slot);
   end

   // short ASCII names, arbitrary bytes, or a fully random word
   function automatic logic [sht_pkg::LABEL_W-1:0] make_label();
      logic [sht_pkg::LABEL_W-1:0] lab;
      int                          chars;
      int                          pick;
      lab   = '0;
      pick  = $urandom_range(0, 99);
      chars = $urandom_range(1, sht_pkg::LABEL_CHARS);
      if (pick < 20) begin
         lab = {16'($urandom()), $urandom()};
      end else begin
         for (int c = 0; c < chars; c++)
            lab[sht_pkg::LABEL_W-1-8*c -: 8] = (pick < 75) ?
                                               8'($urandom_range(8'h21, 8'h7E)) :
                                               8'($urandom_range(0, 255));
      end
      return lab;
   endfunction

   // hold start high when there is no gap, otherwise drop it for the gap
   task automatic send_beat(input sht_pkg::op_type op,
                            input logic [sht_pkg::LABEL_W-1:0] lab,
                            input logic [sht_pkg::ADDR_W-1:0] addr, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_type    <= op;
      req_label   <= lab;
      req_address <= addr;
      do @(posedge clock); while (busy);
      sb.note_request(op, lab);
      beats_sent++;
   endtask

   initial begin
      int                          mode;
      int                          span;
      int                          ins_pct;
      bit                          no_idle;
      bit                          cut;
      sht_pkg::op_type             op;
      logic [sht_pkg::LABEL_W-1:0] lab;
      int                          r;
      int                          idx;
      int                          directed;

      sb          = new();
      beats_sent  = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_type    = sht_pkg::OP_INSERT;
      req_label   = '0;
      req_address = '0;
      foreach (label_pool[i]) label_pool[i] = make_label();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // label zero, all-ones label, substring deletes, collisions, stale slots, wrap
      send_beat(sht_pkg::OP_INSERT, LBL_ZERO, 24'h000000, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_ONES, 24'hFFFFFF, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_ZERO, 24'h123456, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_ABC,  24'h000010, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_DELETE, LBL_AB,   24'hFFFFFF, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_AB,   24'h000020, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_BA,   24'h000030, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_DELETE, LBL_AB,   24'h000000, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_BA,   24'h000031, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_DELETE, LBL_AB,   24'h000000, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_AB,   24'h000021, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_1F,   24'h00001F, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_3F,   24'h00003F, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_DELETE, LBL_ABC,  24'hABCDEF, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_DELETE, LBL_ABC,  24'h000000, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_DELETE, LBL_ZERO, 24'h000000, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_3F,   24'h000040, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_DELETE, LBL_ONES, 24'hFFFFFF, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_ONES, 24'h555555, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_DELETE, LBL_1F,   24'h000000, $urandom_range(0, 8));
      send_beat(sht_pkg::OP_INSERT, LBL_1F,   24'hAAAAAA, $urandom_range(0, 8));
      directed = beats_sent;

      // phases that fill the table, drain it, or mix, so full and empty both recur
      while (beats_sent - directed < RANDOM_BEATS) begin
         mode    = $urandom_range(0, 2);
         span    = $urandom_range(30, 90);
         ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
         no_idle = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < span && beats_sent - directed < RANDOM_BEATS; k++) begin
            op  = ($urandom_range(0, 99) < ins_pct) ? sht_pkg::OP_INSERT : sht_pkg::OP_DELETE;
            r   = $urandom_range(0, 99);
            idx = $urandom_range(0, POOL_SIZE - 1);
            if (r < 75) begin
               lab = label_pool[idx];
            end else if (r < 85 && op == sht_pkg::OP_DELETE) begin
               // drop the last nonzero character to probe for partial matches
               lab = label_pool[idx];
               cut = 1'b0;
               for (int b = 0; b < sht_pkg::LABEL_CHARS; b++) begin
                  if (!cut && lab[8*b +: 8] != 8'h00) begin
                     lab[8*b +: 8] = 8'h00;
                     cut = 1'b1;
                  end
               end
            end else begin
               lab = make_label();
               label_pool[idx] = lab;
            end
            send_beat(op, lab, 24'($urandom()), no_idle ? 0 : $urandom_range(0, 8));
         end
      end
      start <= 1'b0;

      while (sb.outstanding() > 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Covered %0d requests: %0d placed, %0d duplicates, %0d refused as full,",
               beats_sent, sb.n_ins, sb.n_dup, sb.n_full);
      $display("%0d deletes that hit and %0d that missed; %0d result errors.",
               sb.n_del, sb.n_miss, sb.errors);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Run timed out with %0d results outstanding", sb.outstanding());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
src/sht_pkg.sv
src/sht_ram.sv
src/sht_queue.sv
src/sht_front.sv
src/sht_back.sv
src/symbol_hash_table_top.sv
verif/symbol_hash_table_top_tb.sv
